[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle
`define OLQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list queue check failed");

// Implication in the next cycle
`define OLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list queue check failed");

`endif

[sv/ordlq_pkg.sv]
// ----------------------------------------------------------------------------
// ordlq_pkg
// Operation codes and the operation type of the ordered list queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ordlq_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_APPEND  = 2'd0;
    localparam t_op OP_PUSH    = 2'd1;
    localparam t_op OP_ORDERED = 2'd2;
    localparam t_op OP_REMOVE  = 2'd3;

endpackage

`default_nettype wire

[sv/ordered_list_queue.sv]
// ----------------------------------------------------------------------------
// ordered_list_queue
// Result: append, push, rejected insert, remove on empty and ordered insert into
//   an empty list load the output register at accept; a remove reads the head
//   into the read register first (one memory read), then loads the output.
// Other ordered inserts walk the entries at or below the new value toward the
//   head, then place it; one read port, one entry a cycle. Throughput: one word
//   per cycle for ops that finish at accept while results are taken, one op at a time otherwise.
// Reset: state to idle; count, head pointer, compare mode and output valid cleared; memory not swept.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_queue #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_wdata,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_operation,
    input  wire logic [VALUE_WIDTH-1:0]         i_value,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [VALUE_WIDTH-1:0]              o_head_value,
    output logic                                o_removed_valid,
    output logic                                o_accepted,
    output logic [$clog2(DEPTH+1)-1:0]          o_entry_count
);

    // Physical address width and logical count width
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;  // accepting words
    localparam logic [1:0] ST_POP   = 2'd1;  // head read in flight
    localparam logic [1:0] ST_SCAN  = 2'd2;  // walking from head toward tail
    localparam logic [1:0] ST_PLACE = 2'd3;  // new value lands at the tail

    // The list lives in a circular buffer: logical k sits at (head + k) mod DEPTH.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, k};
        if (s >= (CW + 1)'(DEPTH)) begin
            s = s - (CW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == '0) begin
            r = AW'(DEPTH - 1);
        end else begin
            r = p - 1'b1;
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // a <= b, with the sign bit flipped in signed mode
    function automatic logic le_cmp(input logic [VALUE_WIDTH-1:0] a,
                                    input logic [VALUE_WIDTH-1:0] b,
                                    input logic                   signed_mode);
        logic [VALUE_WIDTH-1:0] flip;
        flip = '0;
        flip[VALUE_WIDTH-1] = signed_mode;
        return (a ^ flip) <= (b ^ flip);
    endfunction

    // Entry memory: one write and one registered read per cycle
    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;

    // Control state
    logic [1:0]             r_state, n_state;
    logic [AW-1:0]          r_head,  n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_slot,  n_slot;   // logical index of the entry under test
    logic [VALUE_WIDTH-1:0] r_val,   n_val;    // value being placed
    logic                   r_mode;

    // Output register
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_head;
    logic                   r_out_rvalid;
    logic                   r_out_acc;
    logic [CW-1:0]          r_out_count;

    logic                   out_load;
    logic [VALUE_WIDTH-1:0] out_head;
    logic                   out_rvalid;
    logic                   out_acc;
    logic [CW-1:0]          out_count;

    logic                   in_ready;
    logic                   accept;
    logic                   full;

    // The output slot is empty whenever a remove or a walking ordered insert runs: it was free
    // at accept and only ops that finish at accept load it then. So finishing never waits.
    assign in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept   = i_in_valid && in_ready;
    assign full     = (r_count == CW'(DEPTH));

    // Ordered insert into a non-empty list walks from the head. Entries at or below
    // the new value each move one slot toward the head into the free slot just ahead
    // of the list; the first larger entry stops the walk and the value fills the hole,
    // or goes last if none is larger. The head pointer then steps back by one. The
    // hole trails the read by two entries, so a read and a write never hit the same entry
    // in one cycle, and every write completes before the next word's read is issued.
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_slot     = r_slot;
        n_val      = r_val;
        mem_we     = 1'b0;
        mem_waddr  = phys(r_head, r_slot);
        mem_wdata  = r_val;
        mem_re     = 1'b0;
        mem_raddr  = r_head;
        out_load   = 1'b0;
        out_head   = '0;
        out_rvalid = 1'b0;
        out_acc    = 1'b1;
        out_count  = r_count;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == ordlq_pkg::OP_REMOVE) begin
                        if (r_count == '0) begin
                            out_load = 1'b1;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = r_head;
                            n_head    = ptr_inc(r_head);
                            n_count   = r_count - 1'b1;
                            n_state   = ST_POP;
                        end
                    end else if (full) begin
                        out_load = 1'b1;
                        out_acc  = 1'b0;
                    end else begin
                        unique case (i_operation)
                            ordlq_pkg::OP_APPEND: begin
                                mem_we    = 1'b1;
                                mem_waddr = phys(r_head, r_count);
                                mem_wdata = i_value;
                                n_count   = r_count + 1'b1;
                                out_load  = 1'b1;
                                out_count = r_count + 1'b1;
                            end
                            ordlq_pkg::OP_PUSH: begin
                                mem_we    = 1'b1;
                                mem_waddr = ptr_dec(r_head);
                                mem_wdata = i_value;
                                n_head    = ptr_dec(r_head);
                                n_count   = r_count + 1'b1;
                                out_load  = 1'b1;
                                out_count = r_count + 1'b1;
                            end
                            default: begin
                                // ordered insert
                                if (r_count == '0) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = r_head;
                                    mem_wdata = i_value;
                                    n_count   = r_count + 1'b1;
                                    out_load  = 1'b1;
                                    out_count = r_count + 1'b1;
                                end else begin
                                    n_val     = i_value;
                                    n_slot    = '0;
                                    mem_re    = 1'b1;
                                    mem_raddr = r_head;
                                    n_state   = ST_SCAN;
                                end
                            end
                        endcase
                    end
                end
            end

            ST_POP: begin
                out_load   = 1'b1;
                out_head   = r_rdata;
                out_rvalid = 1'b1;
                n_state    = ST_IDLE;
            end

            ST_SCAN: begin
                // r_rdata holds logical entry r_slot; the hole sits just ahead of it
                mem_we    = 1'b1;
                mem_waddr = phys(ptr_dec(r_head), r_slot);
                if (le_cmp(r_rdata, r_val, r_mode)) begin
                    mem_wdata = r_rdata;
                    n_slot    = r_slot + 1'b1;
                    if (n_slot == r_count) begin
                        n_state = ST_PLACE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(r_head, n_slot);
                    end
                end else begin
                    mem_wdata = r_val;
                    n_head    = ptr_dec(r_head);
                    n_count   = r_count + 1'b1;
                    out_load  = 1'b1;
                    out_count = r_count + 1'b1;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                // ST_PLACE: every entry was at or below the value, it goes last
                mem_we    = 1'b1;
                mem_waddr = phys(ptr_dec(r_head), r_slot);
                mem_wdata = r_val;
                n_head    = ptr_dec(r_head);
                n_count   = r_count + 1'b1;
                out_load  = 1'b1;
                out_count = r_count + 1'b1;
                n_state   = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_val  <= n_val;
        if (out_load) begin
            r_out_head   <= out_head;
            r_out_rvalid <= out_rvalid;
            r_out_acc    <= out_acc;
            r_out_count  <= out_count;
        end
    end

    assign o_in_ready      = in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_head_value    = r_out_head;
    assign o_removed_valid = r_out_rvalid;
    assign o_accepted      = r_out_acc;
    assign o_entry_count   = r_out_count;

endmodule

`default_nettype wire

[sv/ordlq_checker.sv]
// ----------------------------------------------------------------------------
// ordlq_checker
// Port-level checks on the ordered list queue, bound into every ordered_list_queue instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ordlq_checker #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [VALUE_WIDTH-1:0]     o_head_value,
    input wire logic                       o_removed_valid,
    input wire logic                       o_accepted,
    input wire logic [$clog2(DEPTH+1)-1:0] o_entry_count
);

    `OLQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    `OLQ_ASSERT_SAME(a_count_range, i_clk, i_rst_n, o_out_valid, o_entry_count <= DEPTH)

    `OLQ_ASSERT_SAME(a_reject_full, i_clk, i_rst_n, o_out_valid && !o_accepted,
                     o_entry_count == DEPTH && !o_removed_valid)

    `OLQ_ASSERT_SAME(a_head_zero, i_clk, i_rst_n, o_out_valid && !o_removed_valid,
                     o_head_value == '0)

    `OLQ_ASSERT_SAME(a_remove_room, i_clk, i_rst_n, o_out_valid && o_removed_valid,
                     o_accepted && o_entry_count < DEPTH)

endmodule

bind ordered_list_queue ordlq_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ordlq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_head_value    (o_head_value),
    .o_removed_valid (o_removed_valid),
    .o_accepted      (o_accepted),
    .o_entry_count   (o_entry_count)
);

`default_nettype wire

[dv/ordered_list_queue_tb.sv]
// ----------------------------------------------------------------------------
// ordered_list_queue_tb
// Self-checking bench for the ordered list queue. A behavioral list in the
// bench predicts every result word. Directed tests cover the value extremes,
// both compare modes and the empty and full corners. A long receiver hold
// stalls the input. Random phases alternate the compare mode and shift the
// operation mix between filling, draining and even.
// ----------------------------------------------------------------------------
module ordered_list_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = 16;
    localparam int VALUE_WIDTH   = 32;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 5;
    // idle wait after the last result word, longer than the longest ordered insert
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_WORDS   = 300;
    localparam int TIMEOUT_NS    = 2_000_000;

    // one result word as the block returns it
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] head_value;
        logic                   removed_valid;
        logic                   accepted;
        logic [CNT_W-1:0]       entry_count;
    } t_olq_result;

    // receiver stall styles
    typedef enum logic [1:0] {
        READY_ALWAYS, READY_LOOSE, READY_TIGHT, READY_PERIODIC
    } t_ready_style;

    // operation mix of a random stretch
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_op_mix;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic                   i_cfg_wdata = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic [1:0]             i_operation = ordlq_pkg::OP_APPEND;
    logic [VALUE_WIDTH-1:0] i_value     = '0;
    logic                   i_out_ready = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [VALUE_WIDTH-1:0] o_head_value;
    logic                   o_removed_valid;
    logic                   o_accepted;
    logic [CNT_W-1:0]       o_entry_count;

    // bench copy of the list: index 0 is the head
    logic [VALUE_WIDTH-1:0] list_model[$];
    logic                   signed_order = 1'b0;
    t_olq_result            pending_results[$];
    int                     fail_count = 0;

    // sender burst state
    int                     burst_left  = 0;
    bit                     steady_send = 1'b0;

    // long receiver hold: tests bump hold_seq, the receiver counts it out
    int                     hold_seq  = 0;
    int                     hold_seen = 0;
    int                     stall_left = 0;
    t_ready_style           ready_style = READY_ALWAYS;
    int                     style_left  = 0;

    ordered_list_queue #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_head_value    (o_head_value),
        .o_removed_valid (o_removed_valid),
        .o_accepted      (o_accepted),
        .o_entry_count   (o_entry_count)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------------

    // a sorts at or ahead of b under the current compare mode
    function automatic bit sorts_at_or_before(logic [VALUE_WIDTH-1:0] a,
                                              logic [VALUE_WIDTH-1:0] b);
        if (signed_order)
            return $signed(a) <= $signed(b);
        return a <= b;
    endfunction

    // apply one operation to the list model and return the word it gives
    function automatic t_olq_result apply_list_op(ordlq_pkg::t_op op,
                                                  logic [VALUE_WIDTH-1:0] v);
        t_olq_result r;
        int          pos;
        r          = '0;
        r.accepted = 1'b1;
        if (op == ordlq_pkg::OP_REMOVE) begin
            // remove on empty gives zero head and no valid flag
            if (list_model.size() > 0) begin
                r.head_value    = list_model.pop_front();
                r.removed_valid = 1'b1;
            end
        end else if (list_model.size() >= DEPTH) begin
            // any insert into a full list is rejected, list untouched
            r.accepted = 1'b0;
        end else begin
            case (op)
                ordlq_pkg::OP_APPEND: begin
                    list_model.push_back(v);
                end
                ordlq_pkg::OP_PUSH: begin
                    list_model.push_front(v);
                end
                default: begin
                    // after every entry at or below v: equal values keep arrival order
                    pos = 0;
                    while (pos < list_model.size() && sorts_at_or_before(list_model[pos], v))
                        pos++;
                    list_model.insert(pos, v);
                end
            endcase
        end
        r.entry_count = CNT_W'(list_model.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // offer one word; bursts of random length with random gaps between them
    task automatic send_word(ordlq_pkg::t_op op, logic [VALUE_WIDTH-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = 0;
            if (!steady_send && $urandom_range(0, 2) != 0)
                gap = $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= v;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(apply_list_op(op, v));
    endtask

    // drop valid, wait for every result word, then let the block settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called while the block is idle
    task automatic write_compare_mode(logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        signed_order = mode;
        i_cfg_we    <= 1'b0;
    endtask

    // full-range values half the time, plus small ones for ties and values around
    // the sign boundary where the two compare modes disagree
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        case ($urandom_range(0, 3))
            0:       return VALUE_WIDTH'($urandom_range(0, 7));
            1:       return VALUE_WIDTH'(32'h8000_0000 + $urandom_range(0, 15) - 8);
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic ordlq_pkg::t_op random_insert_op();
        case ($urandom_range(0, 2))
            0:       return ordlq_pkg::OP_APPEND;
            1:       return ordlq_pkg::OP_PUSH;
            default: return ordlq_pkg::OP_ORDERED;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: own stall pattern, plus the long hold on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen   <= hold_seq;
            stall_left  <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                ready_style <= t_ready_style'($urandom_range(0, 3));
                style_left  <= $urandom_range(20, 120);
            end else begin
                style_left <= style_left - 1;
            end
            case (ready_style)
                READY_ALWAYS:   i_out_ready <= 1'b1;
                READY_LOOSE:    i_out_ready <= ($urandom_range(0, 99) < 85);
                READY_TIGHT:    i_out_ready <= ($urandom_range(0, 1) == 0);
                default:        i_out_ready <= style_left[2];
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted word against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [VALUE_WIDTH-1:0] want,
                               logic [VALUE_WIDTH-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_olq_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word arrived with none pending");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("head_value", want.head_value, o_head_value);
                check_field("removed_valid", want.removed_valid, o_removed_valid);
                check_field("accepted", want.accepted, o_accepted);
                check_field("entry_count", want.entry_count, o_entry_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // remove on an empty list
    task automatic test_remove_empty();
        send_word(ordlq_pkg::OP_REMOVE, 32'hDEAD_BEEF);
        wait_idle();
    endtask

    // unsigned order: extremes, sign boundary, ties, then head and tail ops, then removes past empty
    task automatic test_unsigned_order();
        write_compare_mode(1'b0);
        send_word(ordlq_pkg::OP_ORDERED, 32'h8000_0000);
        send_word(ordlq_pkg::OP_ORDERED, 32'h7FFF_FFFF);
        send_word(ordlq_pkg::OP_ORDERED, 32'hFFFF_FFFF);
        send_word(ordlq_pkg::OP_ORDERED, 32'h0000_0000);
        send_word(ordlq_pkg::OP_ORDERED, 32'h0000_0005);
        send_word(ordlq_pkg::OP_ORDERED, 32'h0000_0005);
        send_word(ordlq_pkg::OP_APPEND,  32'h0000_0003);
        send_word(ordlq_pkg::OP_PUSH,    32'h0000_0009);
        repeat (9) send_word(ordlq_pkg::OP_REMOVE, 32'h0000_0000);
        wait_idle();
    endtask

    // signed order: negatives must land ahead of positives
    task automatic test_signed_order();
        write_compare_mode(1'b1);
        send_word(ordlq_pkg::OP_ORDERED, 32'h8000_0000);
        send_word(ordlq_pkg::OP_ORDERED, 32'h7FFF_FFFF);
        send_word(ordlq_pkg::OP_ORDERED, 32'hFFFF_FFFF);
        send_word(ordlq_pkg::OP_ORDERED, 32'h0000_0000);
        repeat (4) send_word(ordlq_pkg::OP_REMOVE, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    // fill to DEPTH, try each insert on the full list, drain past empty
    task automatic test_full_list();
        while (list_model.size() < DEPTH)
            send_word(random_insert_op(), random_value());
        send_word(ordlq_pkg::OP_APPEND,  random_value());
        send_word(ordlq_pkg::OP_PUSH,    random_value());
        send_word(ordlq_pkg::OP_ORDERED, random_value());
        while (list_model.size() > 0)
            send_word(ordlq_pkg::OP_REMOVE, random_value());
        send_word(ordlq_pkg::OP_REMOVE, random_value());
        wait_idle();
    endtask

    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_backpressure();
        steady_send = 1'b1;
        hold_seq <= hold_seq + 1;
        repeat (40) begin
            if ($urandom_range(0, 3) == 0)
                send_word(ordlq_pkg::OP_REMOVE, random_value());
            else
                send_word(random_insert_op(), random_value());
        end
        steady_send = 1'b0;
        wait_idle();
    endtask

    // random phases, compare mode alternating, op mix drifting between
    // fill-heavy, drain-heavy and even so full and empty are both reached
    task automatic test_random_mix(int phases);
        t_op_mix mix;
        int      remove_pct;
        for (int p = 0; p < phases; p++) begin
            write_compare_mode(p[0]);
            mix = MIX_EVEN;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 40 == 0)
                    mix = t_op_mix'($urandom_range(0, 2));
                case (mix)
                    MIX_FILL:  remove_pct = 15;
                    MIX_DRAIN: remove_pct = 70;
                    default:   remove_pct = 45;
                endcase
                if ($urandom_range(0, 99) < remove_pct)
                    send_word(ordlq_pkg::OP_REMOVE, VALUE_WIDTH'($urandom));
                else
                    send_word(random_insert_op(), random_value());
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_remove_empty();
        test_unsigned_order();
        test_signed_order();
        test_full_list();
        test_backpressure();
        test_random_mix(6);

        wait_idle();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("ordered_list_queue_tb passed");
        else
            $display("ordered_list_queue_tb failed");
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("ordered_list_queue_tb failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/ordlq_pkg.sv
sv/ordered_list_queue.sv
sv/ordlq_checker.sv
dv/ordered_list_queue_tb.sv
